// ===== sv/tilt_pkg.sv =====
// ---------------------------------------------------------------------------
// tilt_pkg
// Shared constants, selector and result-kind codes, and the arctangent
// table used by the tilt angle pipeline.
// ---------------------------------------------------------------------------
package tilt_pkg;

   localparam int SAMPLE_BITS_DEF = 13;
   localparam int FRAC_BITS       = 16;
   localparam int CORDIC_STEPS    = 24;
   localparam int ANGLE_BITS      = 11;
   localparam int ACC_BITS        = 32;
   localparam int RAD_FRAC        = 30;
   localparam int QUARTER_TURN    = 900;

   // angle = acc * 90000 / (157 * 2^30), 1800/3.14 = 90000/157
   localparam int SCALE_NUM       = 90000;
   localparam int SCALE_NUM_BITS  = 17;
   localparam int DIV_CONST       = 157;
   localparam int RECIP           = 427444;   // floor(2^26 / 157)
   localparam int RECIP_BITS      = 19;
   localparam int RECIP_SHIFT     = 26;
   localparam int QUO_BITS        = 12;

   localparam int MID_DEPTH       = 4;
   localparam int OUT_DEPTH       = 2;

   localparam logic [1:0] CMD_Z    = 2'd0;
   localparam logic [1:0] CMD_X    = 2'd1;
   localparam logic [1:0] CMD_Y    = 2'd2;
   localparam logic [1:0] CMD_NONE = 2'd3;

   localparam int KIND_BITS = 3;
   localparam logic [KIND_BITS-1:0] KIND_ZERO   = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_UNDEF  = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_QPOS   = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_QNEG   = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_CORDIC = 3'd4;

   // atan(2^-i) in radians, 30 fraction bits
   function automatic logic [ACC_BITS-1:0] atan_q30(input int idx);
      logic [ACC_BITS-1:0] v;
      case (idx)
         0:  v = 32'd843314856;
         1:  v = 32'd497837829;
         2:  v = 32'd263043836;
         3:  v = 32'd133525158;
         4:  v = 32'd67021686;
         5:  v = 32'd33543515;
         6:  v = 32'd16775850;
         7:  v = 32'd8388437;
         8:  v = 32'd4194282;
         9:  v = 32'd2097149;
         10: v = 32'd1048575;
         11: v = 32'd524287;
         12: v = 32'd262143;
         13: v = 32'd131071;
         14: v = 32'd65535;
         15: v = 32'd32767;
         16: v = 32'd16383;
         17: v = 32'd8191;
         18: v = 32'd4095;
         19: v = 32'd2047;
         20: v = 32'd1023;
         21: v = 32'd511;
         22: v = 32'd255;
         23: v = 32'd127;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== sv/tilt_fifo.sv =====
// ---------------------------------------------------------------------------
// tilt_fifo
// Small register queue with push/full and pop/empty sides.
// ---------------------------------------------------------------------------
module tilt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

endmodule

// ===== sv/tilt_front.sv =====
// ---------------------------------------------------------------------------
// tilt_front
// Accepts a sample, classifies the special cases and computes the root of
// the sum of squares, one root bit per pipeline stage.
// ---------------------------------------------------------------------------
module tilt_front import tilt_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      push,
   output logic                                      full,
   input  logic [1:0]                                cmd,
   input  logic signed [SAMPLE_BITS-1:0]             accel_x,
   input  logic signed [SAMPLE_BITS-1:0]             accel_y,
   input  logic signed [SAMPLE_BITS-1:0]             accel_z,
   output logic                                      out_valid,
   input  logic                                      out_ready,
   output logic [KIND_BITS-1:0]                      out_kind,
   output logic                                      out_root_is_num,
   output logic signed [SAMPLE_BITS-1:0]             out_plain,
   output logic [SAMPLE_BITS+FRAC_BITS-1:0]          out_root
);

   localparam int QW   = SAMPLE_BITS + FRAC_BITS;
   localparam int RADW = 2 * QW;
   localparam int REMW = QW + 2;
   localparam int SUMW = 2 * SAMPLE_BITS;

   logic en;

   // entry selection
   logic signed [SAMPLE_BITS-1:0] a, b, p;
   logic                          rin;
   logic                          root_zero, plain_zero, num_zero, den_zero, num_neg;
   logic [KIND_BITS-1:0]          kind_in;
   logic [SAMPLE_BITS-1:0]        ma, mb;

   always_comb begin
      a   = accel_x;
      b   = accel_y;
      p   = accel_z;
      rin = 1'b0;
      case (cmd)
         CMD_Z: begin
            a = accel_x; b = accel_y; p = accel_z; rin = 1'b1;
         end
         CMD_X: begin
            a = accel_y; b = accel_z; p = accel_x;
         end
         CMD_Y: begin
            a = accel_x; b = accel_z; p = accel_y;
         end
         default: begin
            a = accel_x; b = accel_y; p = accel_z;
         end
      endcase
      root_zero  = (a == '0) && (b == '0);
      plain_zero = (p == '0);
      num_zero   = rin ? root_zero : plain_zero;
      den_zero   = rin ? plain_zero : root_zero;
      num_neg    = rin ? 1'b0 : p[SAMPLE_BITS-1];
      if (cmd == CMD_NONE) begin
         kind_in = KIND_ZERO;
      end else if (num_zero && den_zero) begin
         kind_in = KIND_UNDEF;
      end else if (den_zero) begin
         kind_in = num_neg ? KIND_QNEG : KIND_QPOS;
      end else if (num_zero) begin
         kind_in = KIND_ZERO;
      end else begin
         kind_in = KIND_CORDIC;
      end
      ma = a[SAMPLE_BITS-1] ? SAMPLE_BITS'(-a) : SAMPLE_BITS'(a);
      mb = b[SAMPLE_BITS-1] ? SAMPLE_BITS'(-b) : SAMPLE_BITS'(b);
   end

   // square stage
   logic                          sq_v_ff;
   logic [KIND_BITS-1:0]          sq_kind_ff;
   logic                          sq_rin_ff;
   logic signed [SAMPLE_BITS-1:0] sq_plain_ff;
   logic [SUMW-1:0]               sq_a_ff, sq_b_ff, sq_a_in, sq_b_in;

   assign sq_a_in = SUMW'(ma) * SUMW'(ma);
   assign sq_b_in = SUMW'(mb) * SUMW'(mb);

   // root stages, index 0 holds the radicand
   logic                          v_ff     [QW+1];
   logic [KIND_BITS-1:0]          kind_ff  [QW+1];
   logic                          rin_ff   [QW+1];
   logic signed [SAMPLE_BITS-1:0] plain_ff [QW+1];
   logic [RADW-1:0]               rad_ff   [QW+1];
   logic [REMW-1:0]               rem_ff   [QW+1];
   logic [QW-1:0]                 root_ff  [QW+1];

   assign en   = !v_ff[QW] || out_ready;
   assign full = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff <= 1'b0;
         v_ff[0] <= 1'b0;
      end else if (en) begin
         sq_v_ff <= push;
         v_ff[0] <= sq_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_kind_ff  <= kind_in;
         sq_rin_ff   <= rin;
         sq_plain_ff <= p;
         sq_a_ff     <= sq_a_in;
         sq_b_ff     <= sq_b_in;
         kind_ff[0]  <= sq_kind_ff;
         rin_ff[0]   <= sq_rin_ff;
         plain_ff[0] <= sq_plain_ff;
         rad_ff[0]   <= {sq_a_ff + sq_b_ff, {(2 * FRAC_BITS){1'b0}}};
         rem_ff[0]   <= '0;
         root_ff[0]  <= '0;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_root
      logic [REMW+1:0] tmp, trial;
      logic [REMW-1:0] rem_in;
      logic [QW-1:0]   root_in;

      always_comb begin
         tmp   = {rem_ff[k], rad_ff[k][RADW-1 -: 2]};
         trial = {2'b00, root_ff[k], 2'b01};
         if (tmp >= trial) begin
            rem_in  = REMW'(tmp - trial);
            root_in = {root_ff[k][QW-2:0], 1'b1};
         end else begin
            rem_in  = REMW'(tmp);
            root_in = {root_ff[k][QW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            kind_ff[k+1]  <= kind_ff[k];
            rin_ff[k+1]   <= rin_ff[k];
            plain_ff[k+1] <= plain_ff[k];
            rad_ff[k+1]   <= {rad_ff[k][RADW-3:0], 2'b00};
            rem_ff[k+1]   <= rem_in;
            root_ff[k+1]  <= root_in;
         end
      end
   end

   assign out_valid       = v_ff[QW];
   assign out_kind        = kind_ff[QW];
   assign out_root_is_num = rin_ff[QW];
   assign out_plain       = plain_ff[QW];
   assign out_root        = root_ff[QW];

endmodule

// ===== sv/tilt_back.sv =====
// ---------------------------------------------------------------------------
// tilt_back
// Pipelined CORDIC in vectoring mode, then scaling of the radian sum to
// the output angle and resolution of the special cases.
// ---------------------------------------------------------------------------
module tilt_back import tilt_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [KIND_BITS-1:0]                 in_kind,
   input  logic                                 in_root_is_num,
   input  logic signed [SAMPLE_BITS-1:0]        in_plain,
   input  logic [SAMPLE_BITS+FRAC_BITS-1:0]     in_root,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic signed [ANGLE_BITS-1:0]         angle,
   output logic                                 undefined_flag
);

   localparam int QW   = SAMPLE_BITS + FRAC_BITS;
   localparam int CW   = QW + 3;
   localparam int NST  = CORDIC_STEPS + 4;
   localparam int LAST = NST - 1;
   localparam int PW   = ACC_BITS + SCALE_NUM_BITS;
   localparam int MW   = PW - RAD_FRAC;
   localparam int RPW  = MW + RECIP_BITS;

   logic                 en;
   logic                 v_ff    [NST];
   logic [KIND_BITS-1:0] kind_ff [NST];

   assign en       = !v_ff[LAST] || out_ready;
   assign in_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind_ff[0] <= in_kind;
      end
   end

   for (genvar s = 1; s < NST; s++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            kind_ff[s] <= kind_ff[s-1];
         end
      end
   end

   // operand setup
   logic signed [CW-1:0]       root_s, plain_s, num, den, x0_in, y0_in;
   logic signed [CW-1:0]       x_ff   [CORDIC_STEPS+1];
   logic signed [CW-1:0]       y_ff   [CORDIC_STEPS+1];
   logic signed [ACC_BITS-1:0] acc_ff [CORDIC_STEPS+1];

   always_comb begin
      root_s  = $signed(CW'(in_root));
      plain_s = CW'(in_plain) <<< FRAC_BITS;
      num     = in_root_is_num ? root_s : plain_s;
      den     = in_root_is_num ? plain_s : root_s;
      x0_in   = den[CW-1] ? -den : den;
      y0_in   = den[CW-1] ? -num : num;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= x0_in;
         y_ff[0]   <= y0_in;
         acc_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      logic signed [CW-1:0]       dx, dy, x_in, y_in;
      logic signed [ACC_BITS-1:0] acc_in;

      always_comb begin
         dx = y_ff[i] >>> i;
         dy = x_ff[i] >>> i;
         if (!y_ff[i][CW-1]) begin
            x_in   = x_ff[i] + dx;
            y_in   = y_ff[i] - dy;
            acc_in = acc_ff[i] + $signed(atan_q30(i));
         end else begin
            x_in   = x_ff[i] - dx;
            y_in   = y_ff[i] + dy;
            acc_in = acc_ff[i] - $signed(atan_q30(i));
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]   <= x_in;
            y_ff[i+1]   <= y_in;
            acc_ff[i+1] <= acc_in;
         end
      end
   end

   // scaling: m = floor(|acc| * 90000 / 2^30), then m / 157 by reciprocal
   logic [ACC_BITS-1:0] mag;
   logic [PW-1:0]       prod_in;
   logic [MW-1:0]       m1_ff, m2_ff;
   logic                neg1_ff, neg2_ff;
   logic [RPW-1:0]      rprod_in;
   logic [QUO_BITS-1:0] q0_ff;
   logic [MW-1:0]       rem;
   logic [QUO_BITS-1:0] quo;
   logic [ANGLE_BITS-1:0] amag;
   logic signed [ANGLE_BITS-1:0] angle_in, angle_ff;
   logic                flag_in, flag_ff;
   logic [KIND_BITS-1:0] kind_s3;

   always_comb begin
      mag     = acc_ff[CORDIC_STEPS][ACC_BITS-1] ? ACC_BITS'(-acc_ff[CORDIC_STEPS])
                                                 : ACC_BITS'(acc_ff[CORDIC_STEPS]);
      prod_in = PW'(mag) * PW'(SCALE_NUM);
   end

   assign rprod_in = RPW'(m1_ff) * RPW'(RECIP);

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff   <= prod_in[RAD_FRAC +: MW];
         neg1_ff <= acc_ff[CORDIC_STEPS][ACC_BITS-1];
         m2_ff   <= m1_ff;
         neg2_ff <= neg1_ff;
         q0_ff   <= rprod_in[RECIP_SHIFT +: QUO_BITS];
      end
   end

   assign kind_s3 = kind_ff[LAST-1];

   always_comb begin
      rem      = m2_ff - MW'(q0_ff) * MW'(DIV_CONST);
      quo      = (rem >= MW'(DIV_CONST)) ? q0_ff + 1'b1 : q0_ff;
      amag     = quo[ANGLE_BITS-1:0];
      flag_in  = 1'b0;
      case (kind_s3)
         KIND_UNDEF: begin
            angle_in = '0;
            flag_in  = 1'b1;
         end
         KIND_QPOS: begin
            angle_in = ANGLE_BITS'(QUARTER_TURN);
         end
         KIND_QNEG: begin
            angle_in = -ANGLE_BITS'(QUARTER_TURN);
         end
         KIND_CORDIC: begin
            angle_in = neg2_ff ? -$signed(amag) : $signed(amag);
         end
         default: begin
            angle_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
         flag_ff  <= flag_in;
      end
   end

   assign out_valid      = v_ff[LAST];
   assign angle          = angle_ff;
   assign undefined_flag = flag_ff;

endmodule

// ===== sv/tilt_angle_from_acceleration_top.sv =====
// ---------------------------------------------------------------------------
// tilt_angle_from_acceleration_top
// Tilt angle from a three-axis acceleration sample.
// ---------------------------------------------------------------------------
// Takes one word per cycle while req_full is low and returns one result
// word per input word, in order. The front computes the root of the sum of
// squares one root bit per stage; a four-word queue then feeds the back,
// an operand stage, a 24-stage CORDIC and three scaling stages, ending in
// a two-word result queue. Throughput is one word per cycle while no stall
// holds the pipeline, set by the fully pipelined root and CORDIC stages.
module tilt_angle_from_acceleration_top import tilt_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_cmd,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_z,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [ANGLE_BITS-1:0]  rsp_angle,
   output logic                          rsp_undefined_flag
);

   localparam int QW   = SAMPLE_BITS + FRAC_BITS;
   localparam int MIDW = KIND_BITS + 1 + SAMPLE_BITS + QW;
   localparam int OUTW = ANGLE_BITS + 1;

   logic                          f_valid, f_ready;
   logic [KIND_BITS-1:0]          f_kind, b_kind;
   logic                          f_rin, b_rin;
   logic signed [SAMPLE_BITS-1:0] f_plain, b_plain;
   logic [QW-1:0]                 f_root, b_root;
   logic                          mid_full, mid_empty, mid_pop;
   logic [MIDW-1:0]               mid_rdata;
   logic                          b_ready, b_valid, out_full;
   logic signed [ANGLE_BITS-1:0]  b_angle;
   logic                          b_flag;
   logic [OUTW-1:0]               out_rdata;

   tilt_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (req_push),
      .full            (req_full),
      .cmd             (req_cmd),
      .accel_x         (req_accel_x),
      .accel_y         (req_accel_y),
      .accel_z         (req_accel_z),
      .out_valid       (f_valid),
      .out_ready       (f_ready),
      .out_kind        (f_kind),
      .out_root_is_num (f_rin),
      .out_plain       (f_plain),
      .out_root        (f_root)
   );

   assign f_ready = !mid_full;

   tilt_fifo #(.WIDTH(MIDW), .DEPTH(MID_DEPTH)) u_mid (
      .clock (clock),
      .reset (reset),
      .push  (f_valid),
      .full  (mid_full),
      .wdata ({f_kind, f_rin, f_plain, f_root}),
      .pop   (mid_pop),
      .empty (mid_empty),
      .rdata (mid_rdata)
   );

   assign mid_pop = b_ready && !mid_empty;
   assign {b_kind, b_rin, b_plain, b_root} = mid_rdata;

   tilt_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (!mid_empty),
      .in_ready       (b_ready),
      .in_kind        (b_kind),
      .in_root_is_num (b_rin),
      .in_plain       (b_plain),
      .in_root        (b_root),
      .out_valid      (b_valid),
      .out_ready      (!out_full),
      .angle          (b_angle),
      .undefined_flag (b_flag)
   );

   tilt_fifo #(.WIDTH(OUTW), .DEPTH(OUT_DEPTH)) u_out (
      .clock (clock),
      .reset (reset),
      .push  (b_valid),
      .full  (out_full),
      .wdata ({b_angle, b_flag}),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (out_rdata)
   );

   assign rsp_angle          = out_rdata[OUTW-1:1];
   assign rsp_undefined_flag = out_rdata[0];

endmodule

// ===== bench/tilt_angle_from_acceleration_top_tb.sv =====
// ---------------------------------------------------------------------------
// tilt_angle_from_acceleration_top_tb
// Self-checking bench for the tilt angle pipeline: a local fixed-point
// model predicts each angle word, results are compared in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tilt_angle_from_acceleration_top_tb import tilt_pkg::*; ();

   localparam int SB = SAMPLE_BITS_DEF;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [ANGLE_BITS-1:0] angle;
      logic                         undef;
   } tilt_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [1:0] req_cmd = CMD_Z;
   logic signed [SB-1:0] req_accel_x = '0;
   logic signed [SB-1:0] req_accel_y = '0;
   logic signed [SB-1:0] req_accel_z = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [ANGLE_BITS-1:0] rsp_angle;
   logic rsp_undefined_flag;

   tilt_word_type angle_queue[$];
   int  errors = 0;
   int  cycles = 0;
   bit  hold_off = 1'b0;

   tilt_angle_from_acceleration_top #(.SAMPLE_BITS(SB)) u_top (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic longint unsigned isqrt(input longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint hyp(input longint a, input longint b);
      longint unsigned s;
      s = a * a + b * b;
      return longint'(isqrt(s << (2 * FRAC_BITS)));
   endfunction

   function automatic longint atan_entry(input int i);
      longint t[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                        33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                        524287, 262143, 131071, 65535, 32767, 16383, 8191,
                        4095, 2047, 1023, 511, 255, 127};
      return t[i];
   endfunction

   function automatic tilt_word_type predict_tilt(input logic [1:0] cmd,
         input logic signed [SB-1:0] xs, input logic signed [SB-1:0] ys,
         input logic signed [SB-1:0] zs);
      tilt_word_type w;
      longint ax, ay, az, num, den, cx, cy, dx, dy, acc, ang;
      ax = xs; ay = ys; az = zs;
      num = 0; den = 0; ang = 0;
      w.undef = 1'b0;
      case (cmd)
         CMD_Z: begin num = hyp(ax, ay); den = az <<< FRAC_BITS; end
         CMD_X: begin num = ax <<< FRAC_BITS; den = hyp(ay, az); end
         CMD_Y: begin num = ay <<< FRAC_BITS; den = hyp(ax, az); end
         default: ;
      endcase
      if (cmd != CMD_NONE) begin
         if (num == 0 && den == 0) begin
            w.undef = 1'b1;
         end else if (den == 0) begin
            ang = num > 0 ? QUARTER_TURN : -QUARTER_TURN;
         end else if (num != 0) begin
            cx = den < 0 ? -den : den;
            cy = den < 0 ? -num : num;
            acc = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
               dx = cy >>> i;   // arithmetic shift floors
               dy = cx >>> i;
               if (cy >= 0) begin
                  cx += dx; cy -= dy; acc += atan_entry(i);
               end else begin
                  cx -= dx; cy += dy; acc -= atan_entry(i);
               end
            end
            ang = (acc * SCALE_NUM) / (longint'(DIV_CONST) <<< RAD_FRAC);
         end
      end
      w.angle = ang[ANGLE_BITS-1:0];
      return w;
   endfunction

   // push drops only when the gap really spans cycles
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) :
          ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
      if (n != 0) begin
         req_push <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_word(input logic [1:0] cmd, input logic signed [SB-1:0] xs,
         input logic signed [SB-1:0] ys, input logic signed [SB-1:0] zs,
         input bit gaps);
      req_push    <= 1'b1;
      req_cmd     <= cmd;
      req_accel_x <= xs;
      req_accel_y <= ys;
      req_accel_z <= zs;
      do @(posedge clock); while (req_full);
      angle_queue.push_back(predict_tilt(cmd, xs, ys, zs));
      if (gaps && $urandom_range(0, 3) == 0) begin
         idle_gap();
      end
   endtask

   // result checker with random pop stalls
   always @(posedge clock) begin
      tilt_word_type exp_w;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (angle_queue.size() == 0) begin
            $error("unexpected word: angle %0d", rsp_angle);
            errors++;
         end else begin
            exp_w = angle_queue.pop_front();
            if (rsp_angle !== exp_w.angle) begin
               $error("angle expected %0d actual %0d", exp_w.angle, rsp_angle);
               errors++;
            end
            if (rsp_undefined_flag !== exp_w.undef) begin
               $error("undefined_flag expected %0d actual %0d", exp_w.undef,
                      rsp_undefined_flag);
               errors++;
            end
         end
      end
      if (hold_off) rsp_pop <= 1'b0;
      else if ($urandom_range(0, 39) == 0) rsp_pop <= 1'b0;
      else rsp_pop <= ($urandom_range(0, 3) != 0);
   end

   task automatic test_directed();
      logic signed [SB-1:0] mx, mn;
      mx = {1'b0, {(SB-1){1'b1}}};
      mn = {1'b1, {(SB-1){1'b0}}};
      for (int c = 0; c < 4; c++) begin
         send_word(c[1:0], 0, 0, 0, 0);          // zero over zero
         send_word(c[1:0], mx, mx, mx, 0);
         send_word(c[1:0], mn, mn, mn, 0);
         send_word(c[1:0], mx, mn, 0, 1);
         send_word(c[1:0], 0, 0, mn, 0);
      end
      send_word(CMD_Z, 5, -3, 0, 0);             // zero denominator
      send_word(CMD_X, -7, 0, 0, 0);
      send_word(CMD_Y, 0, 9, 0, 0);
      send_word(CMD_X, 0, 4, -4, 0);             // zero numerator
      send_word(CMD_Z, 1, 0, -1, 0);
      req_push <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_random(input int n);
      logic signed [SB-1:0] v[3];
      for (int k = 0; k < n; k++) begin
         for (int j = 0; j < 3; j++) begin
            case ($urandom_range(0, 5))
               0: v[j] = '0;
               1: v[j] = SB'($urandom_range(0, 15) - 8);
               default: v[j] = SB'($urandom);
            endcase
         end
         send_word(2'($urandom_range(0, 3)), v[0], v[1], v[2], 1);
      end
      req_push <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         test_random(150);
      join
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(600);
      test_backpressure();
      test_random(450);
      while (angle_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
